// ===== hdl/cfcr_pkg.sv =====
// ----------------------------------------------------------------------------
// cfcr_pkg
// Types and constants shared by the command frame checker and responder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfcr_pkg;

    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned ECHO_LEN  = 4;

    localparam logic [7:0] ESC_BYTE  = 8'h1b;
    localparam logic [7:0] CMD_BOOST = 8'h48;  // 'H'
    localparam logic [7:0] RSP_TAG   = 8'h45;  // 'E'
    localparam logic [7:0] ZONE_ONE  = 8'd1;
    localparam logic [7:0] ZONE_TWO  = 8'd2;

    localparam logic [7:0] TARGET_MIN_RESET = 8'd50;
    localparam logic [7:0] TARGET_MAX_RESET = 8'd74;

    // Status codes carried in every response.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CHECKSUM = 3'd1;
    localparam logic [2:0] ST_TARGET   = 3'd2;
    localparam logic [2:0] ST_ZONE     = 3'd3;
    localparam logic [2:0] ST_COMMAND  = 3'd4;
    localparam logic [2:0] ST_NO_ESC   = 3'd5;
    localparam logic [2:0] ST_LENGTH   = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_TARGET_MIN = 1'b0;
    localparam logic CFG_TARGET_MAX = 1'b1;

    // Response byte positions.
    localparam logic [2:0] RSP_IDX_ESC  = 3'd0;
    localparam logic [2:0] RSP_IDX_TAG  = 3'd1;
    localparam logic [2:0] RSP_IDX_CODE = 3'd2;
    localparam logic [2:0] RSP_IDX_SUM  = 3'd7;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t one_target;
        byte_t one_minutes;
        byte_t two_target;
        byte_t two_minutes;
    } zone_state_t;

endpackage

`default_nettype wire

// ===== hdl/command_frame_checker_responder.sv =====
// ----------------------------------------------------------------------------
// command_frame_checker_responder
// Collects the bytes of one command transaction, checks the frame at its end,
// updates the zone boost settings and streams an eight-byte response.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  s_      | in        | tdata = rx_byte, tlast = rx_end
//  m_      | out       | tdata = tx_byte, status, zone settings; tlast = tx_end
//  cfg_    | in        | index 0 target_min, index 1 target_max
//
//  One received byte is taken every cycle. The final byte's transfer sets a
//  check flag; the frame is then checked and an eight-byte response streams
//  on m_. Input stalls only while a finished frame waits for the previous
//  response's last byte to leave. Reset (aresetn low, synchronous) clears
//  the buffer, the counter and the zone settings.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_checker_responder
    import cfcr_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // [7:0] tx_byte, [10:8] status_code,
                                   // [18:11] zone_one_target, [26:19] zone_one_minutes,
                                   // [34:27] zone_two_target, [42:35] zone_two_minutes,
                                   // [47:43] zero
    output logic        m_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire         cfg_index,
    input  wire  [7:0]  cfg_data
);

    byte_t       frame_reg [FRAME_LEN];
    logic [3:0]  count_reg;
    logic        check_reg;
    logic        len_ok_reg;
    byte_t       tmin_reg;
    byte_t       tmax_reg;
    zone_state_t zones_reg;

    logic        busy_reg;
    logic [2:0]  idx_reg;
    logic [2:0]  code_reg;
    byte_t       echo_reg [ECHO_LEN];
    byte_t       base_reg;
    zone_state_t snap_reg;

    logic        s_xfer;
    logic        load_ok;
    logic        load;
    logic        count_full;
    logic [3:0]  count_next;
    logic [2:0]  status;
    zone_state_t zones_next;
    byte_t       base_next;
    byte_t       tx_byte;

    assign cfg_ready  = 1'b1;
    assign load_ok    = !busy_reg || (m_tready && (idx_reg == RSP_IDX_SUM));
    assign load       = check_reg && load_ok;
    assign s_tready   = !check_reg || load_ok;
    assign s_xfer     = s_tvalid && s_tready;
    assign count_full = (count_reg == 4'(FRAME_LEN));
    assign count_next = count_full ? count_reg : count_reg + 4'd1;

    cfcr_check u_check (
        .frame      (frame_reg),
        .len_ok     (len_ok_reg),
        .target_min (tmin_reg),
        .target_max (tmax_reg),
        .zones      (zones_reg),
        .status     (status),
        .zones_next (zones_next)
    );

    // Partial response checksum; the status code is added on the way out.
    assign base_next = ESC_BYTE + RSP_TAG + frame_reg[0] + frame_reg[1]
                     + frame_reg[2] + frame_reg[3];

    // Frame collection and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                frame_reg[i] <= '0;
            end
            count_reg  <= '0;
            check_reg  <= 1'b0;
            len_ok_reg <= 1'b0;
            tmin_reg   <= TARGET_MIN_RESET;
            tmax_reg   <= TARGET_MAX_RESET;
            zones_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_TARGET_MIN: tmin_reg <= cfg_data;
                    CFG_TARGET_MAX: tmax_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (load) begin
                zones_reg <= zones_next;
            end
            // A final byte may arrive in the same cycle the pending frame is taken.
            if (s_xfer && s_tlast) begin
                check_reg <= 1'b1;
            end else if (load) begin
                check_reg <= 1'b0;
            end
            if (s_xfer) begin
                if (!count_full) begin
                    frame_reg[count_reg[2:0]] <= s_tdata;
                end
                if (s_tlast) begin
                    count_reg  <= '0;
                    len_ok_reg <= (count_next == 4'(FRAME_LEN));
                end else begin
                    count_reg <= count_next;
                end
            end
        end
    end

    // Response sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (busy_reg && m_tready) begin
            if (idx_reg == RSP_IDX_SUM) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= status;
            base_reg <= base_next;
            snap_reg <= zones_next;
            for (int i = 0; i < ECHO_LEN; i++) begin
                echo_reg[i] <= frame_reg[i];
            end
        end
    end

    always_comb begin
        case (idx_reg)
            RSP_IDX_ESC:  tx_byte = ESC_BYTE;
            RSP_IDX_TAG:  tx_byte = RSP_TAG;
            RSP_IDX_CODE: tx_byte = {5'd0, code_reg};
            RSP_IDX_SUM:  tx_byte = base_reg + {5'd0, code_reg};
            default:      tx_byte = echo_reg[2'(idx_reg - 3'd3)];
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = (idx_reg == RSP_IDX_SUM);
    assign m_tdata  = {5'd0, snap_reg.two_minutes, snap_reg.two_target,
                       snap_reg.one_minutes, snap_reg.one_target, code_reg, tx_byte};

endmodule

`default_nettype wire

// ===== hdl/cfcr_check.sv =====
// ----------------------------------------------------------------------------
// cfcr_check
// Validates a completed frame and computes the status code and the zone
// settings that result from it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfcr_check
    import cfcr_pkg::*;
(
    input  var byte_t       frame   [FRAME_LEN],
    input  wire             len_ok,
    input  var byte_t       target_min,
    input  var byte_t       target_max,
    input  var zone_state_t zones,
    output logic [2:0]      status,
    output zone_state_t     zones_next
);

    byte_t sum7;
    logic  in_range;

    always_comb begin
        sum7 = '0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            sum7 = sum7 + frame[i];
        end
    end

    assign in_range = (frame[3] >= target_min) && (frame[3] <= target_max);

    always_comb begin
        zones_next = zones;
        if (!len_ok) begin
            status = ST_LENGTH;
        end else if (sum7 != frame[FRAME_LEN-1]) begin
            status = ST_CHECKSUM;
        end else if (frame[0] != ESC_BYTE) begin
            status = ST_NO_ESC;
        end else if (frame[1] != CMD_BOOST) begin
            status = ST_COMMAND;
        end else if (frame[2] == ZONE_ONE) begin
            if (in_range) begin
                status                 = ST_OK;
                zones_next.one_target  = frame[3];
                zones_next.one_minutes = frame[4];
            end else begin
                status                 = ST_TARGET;
                zones_next.one_minutes = '0;
            end
        end else if (frame[2] == ZONE_TWO) begin
            if (in_range) begin
                status                 = ST_OK;
                zones_next.two_target  = frame[3];
                zones_next.two_minutes = frame[4];
            end else begin
                status                 = ST_TARGET;
                zones_next.two_minutes = '0;
            end
        end else begin
            status                 = ST_ZONE;
            zones_next.one_minutes = '0;
            zones_next.two_minutes = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cfcr_checker.sv =====
// ----------------------------------------------------------------------------
// cfcr_checker
// Port-level checks on the command frame checker and responder.
// ----------------------------------------------------------------------------
`default_nettype none

module cfcr_checker
    import cfcr_pkg::*;
(
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [47:0] m_tdata,
    input wire        m_tlast
);

    // A stalled result transfer holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // A response streams without gaps until its last byte.
    a_no_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a response");

    // Whatever follows the end of a response opens with ESC.
    a_start_esc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || (m_tdata[7:0] == ESC_BYTE))
        else $error("response does not open with ESC");

    // Status codes stay within the defined set.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:8] <= ST_LENGTH))
        else $error("status code out of range");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind command_frame_checker_responder cfcr_checker u_cfcr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== dv/command_frame_checker_responder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_frame_checker_responder_tb
// Streams command transactions into the frame checker and compares every
// response transfer against a local model of the checks, the zone settings
// and the response bytes. Both stream sides idle at random, and the target
// range is reprogrammed between phases, including an empty range.
// ----------------------------------------------------------------------------

module command_frame_checker_responder_tb;
    import cfcr_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned HOLD_AFTER    = 60;

    typedef struct {
        byte_t data;
        logic  last;
    } rx_item_t;

    typedef struct {
        byte_t       tx_byte;
        logic        tx_end;
        logic [2:0]  status;
        zone_state_t zones;
    } rsp_item_t;

    typedef byte_t frame_q_t[$];

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    wire         m_tvalid;
    logic        m_tready  = 1'b0;
    wire  [47:0] m_tdata;
    wire         m_tlast;
    logic        cfg_valid = 1'b0;
    wire         cfg_ready;
    logic        cfg_index = CFG_TARGET_MIN;
    logic [7:0]  cfg_data  = '0;

    // Local copy of the block's state and target range.
    byte_t       lim_lo = TARGET_MIN_RESET;
    byte_t       lim_hi = TARGET_MAX_RESET;
    byte_t       frame_buf [FRAME_LEN] = '{default: 8'h00};
    int unsigned frame_cnt = 0;
    zone_state_t zone_now  = '0;

    rx_item_t    rx_q [$];
    rsp_item_t   rsp_q [$];
    int unsigned queued_total = 0;
    int unsigned rx_accepted  = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    int unsigned src_gap      = 0;
    bit          src_calm     = 1'b0;
    int unsigned sink_gap     = 0;
    bit          sink_calm    = 1'b0;

    command_frame_checker_responder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Buffers one received byte and, on the final byte of a transaction,
    // judges the frame and queues the eight response transfers it causes.
    task automatic predict_frame(input byte_t b, input logic last);
        byte_t      sum7;
        logic [2:0] code;
        byte_t      rsp [FRAME_LEN];
        rsp_item_t  r;
        if (frame_cnt < FRAME_LEN) begin
            frame_buf[frame_cnt] = b;
            frame_cnt++;
        end
        if (!last) return;
        sum7 = '0;
        for (int i = 0; i < 7; i++) sum7 += frame_buf[i];
        if (frame_cnt != FRAME_LEN) begin
            code = ST_LENGTH;
        end else if (sum7 != frame_buf[7]) begin
            code = ST_CHECKSUM;
        end else if (frame_buf[0] != ESC_BYTE) begin
            code = ST_NO_ESC;
        end else if (frame_buf[1] != CMD_BOOST) begin
            code = ST_COMMAND;
        end else if (frame_buf[2] != ZONE_ONE && frame_buf[2] != ZONE_TWO) begin
            code = ST_ZONE;
            zone_now.one_minutes = '0;
            zone_now.two_minutes = '0;
        end else if (frame_buf[3] < lim_lo || frame_buf[3] > lim_hi) begin
            // Out of range: only the addressed zone loses its duration.
            code = ST_TARGET;
            if (frame_buf[2] == ZONE_ONE) zone_now.one_minutes = '0;
            else zone_now.two_minutes = '0;
        end else begin
            code = ST_OK;
            if (frame_buf[2] == ZONE_ONE) begin
                zone_now.one_target  = frame_buf[3];
                zone_now.one_minutes = frame_buf[4];
            end else begin
                zone_now.two_target  = frame_buf[3];
                zone_now.two_minutes = frame_buf[4];
            end
        end
        frame_cnt = 0;

        rsp[RSP_IDX_ESC]  = ESC_BYTE;
        rsp[RSP_IDX_TAG]  = RSP_TAG;
        rsp[RSP_IDX_CODE] = {5'b0, code};
        for (int i = 0; i < ECHO_LEN; i++) rsp[RSP_IDX_CODE + 1 + i] = frame_buf[i];
        rsp[RSP_IDX_SUM] = '0;
        for (int i = 0; i < RSP_IDX_SUM; i++) rsp[RSP_IDX_SUM] += rsp[i];
        for (int k = 0; k < FRAME_LEN; k++) begin
            r.tx_byte = rsp[k];
            r.tx_end  = (k == FRAME_LEN - 1);
            r.status  = code;
            r.zones   = zone_now;
            rsp_q.push_back(r);
        end
    endtask

    function automatic int unsigned pick_gap(input bit calm);
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    // Eight-byte boost frame with a correct checksum.
    function automatic frame_q_t boost_frame(input byte_t lead, input byte_t cmd,
                                             input byte_t zone, input byte_t target,
                                             input byte_t minutes);
        frame_q_t f;
        byte_t    sum;
        f = '{lead, cmd, zone, target, minutes, byte_t'($urandom), byte_t'($urandom)};
        sum = '0;
        foreach (f[i]) sum += f[i];
        f.push_back(sum);
        return f;
    endfunction

    // Favors the range edges and their neighbors just outside.
    function automatic byte_t pick_target();
        case ($urandom_range(0, 9))
            0: return lim_lo;
            1: return lim_hi;
            2: return lim_lo - 8'd1;
            3: return lim_hi + 8'd1;
            4, 5, 6, 7: begin
                if (lim_lo <= lim_hi) return byte_t'($urandom_range(lim_lo, lim_hi));
                return byte_t'($urandom);
            end
            default: return byte_t'($urandom);
        endcase
    endfunction

    task automatic queue_frame(input frame_q_t f);
        rx_item_t it;
        foreach (f[i]) begin
            it.data = f[i];
            it.last = (i == f.size() - 1);
            rx_q.push_back(it);
        end
        queued_total += f.size();
    endtask

    task automatic queue_random_frame();
        frame_q_t f;
        byte_t    zone;
        byte_t    minutes;
        int       kind;
        zone    = ($urandom_range(0, 1) != 0) ? ZONE_ONE : ZONE_TWO;
        minutes = ($urandom_range(0, 7) == 0) ? 8'h00 : byte_t'($urandom);
        kind    = $urandom_range(0, 99);
        if (kind < 55) begin
            f = boost_frame(ESC_BYTE, CMD_BOOST, zone, pick_target(), minutes);
        end else if (kind < 63) begin
            f = boost_frame(ESC_BYTE, CMD_BOOST, zone, pick_target(), minutes);
            f[7] ^= byte_t'($urandom_range(1, 255));
        end else if (kind < 70) begin
            f = boost_frame(byte_t'($urandom), CMD_BOOST, zone, pick_target(), minutes);
        end else if (kind < 77) begin
            f = boost_frame(ESC_BYTE, byte_t'($urandom), zone, pick_target(), minutes);
        end else if (kind < 84) begin
            zone = ($urandom_range(0, 1) != 0) ? 8'h00 : byte_t'($urandom_range(3, 255));
            f = boost_frame(ESC_BYTE, CMD_BOOST, zone, pick_target(), minutes);
        end else if (kind < 90) begin
            // Truncated transaction: length error, with a partly stale echo when under four bytes arrive.
            f = boost_frame(ESC_BYTE, CMD_BOOST, zone, pick_target(), minutes);
            f = f[0:$urandom_range(0, 6)];
        end else if (kind < 96) begin
            // Overlong transaction: the tail is dropped by the block.
            f = boost_frame(ESC_BYTE, CMD_BOOST, zone, pick_target(), minutes);
            repeat ($urandom_range(1, 5)) f.push_back(byte_t'($urandom));
        end else begin
            repeat ($urandom_range(1, 12)) f.push_back(byte_t'($urandom));
        end
        queue_frame(f);
    endtask

    task automatic cfg_write(input logic idx, input byte_t val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TARGET_MIN) lim_lo = val;
        else lim_hi = val;
    endtask

    // Waits until every queued byte is taken and every response has arrived.
    task automatic drain();
        do @(posedge aclk); while (rx_q.size() != 0 || s_tvalid || rsp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_phase(input byte_t lo, input byte_t hi, input int unsigned count);
        int unsigned start;
        cfg_write(CFG_TARGET_MIN, lo);
        cfg_write(CFG_TARGET_MAX, hi);
        @(negedge aclk);
        start = queued_total;
        while (queued_total - start < count) queue_random_frame();
        drain();
    endtask

    function automatic void check_field(input string name, input logic [7:0] expected,
                                        input logic [7:0] actual);
        if (expected !== actual) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
            mismatches++;
        end
    endfunction

    // Sender: offers queued bytes and updates the model on every accepted transfer.
    always @(posedge aclk) begin
        rx_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_frame(s_tdata, s_tlast);
                rx_accepted <= rx_accepted + 1;
            end
            if (!s_tvalid || s_tready) begin
                if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
                if (src_gap != 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (rx_q.size() != 0) begin
                    nxt = rx_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                    src_gap  = pick_gap(src_calm);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each response transfer against the oldest expectation.
    always @(posedge aclk) begin
        rsp_item_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (rsp_q.size() == 0) begin
                    $display("%0t: unexpected response transfer, actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    exp_r = rsp_q.pop_front();
                    check_field("tx_byte", exp_r.tx_byte, m_tdata[7:0]);
                    check_field("tx_end", exp_r.tx_end, m_tlast);
                    check_field("status_code", exp_r.status, m_tdata[10:8]);
                    check_field("zone_one_target", exp_r.zones.one_target, m_tdata[18:11]);
                    check_field("zone_one_minutes", exp_r.zones.one_minutes, m_tdata[26:19]);
                    check_field("zone_two_target", exp_r.zones.two_target, m_tdata[34:27]);
                    check_field("zone_two_minutes", exp_r.zones.two_minutes, m_tdata[42:35]);
                end
            end
            if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
            if (sink_gap != 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (hold_left == 0);
                sink_gap = pick_gap(sink_calm);
            end
        end
    end

    // One long receiver hold-off so that a response backs up and input stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && rx_accepted >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL command_frame_checker_responder");
            $finish;
        end
    end

    initial begin
        frame_q_t f;
        byte_t    lo;
        byte_t    hi;
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Clean boost for zone one at the bottom of the reset range.
        queue_frame(boost_frame(ESC_BYTE, CMD_BOOST, ZONE_ONE, lim_lo, 8'hff));
        // A zone byte other than one or two clears both durations.
        queue_frame(boost_frame(ESC_BYTE, CMD_BOOST, 8'h00, lim_hi, 8'h00));
        // A single-byte transaction fails the length check and echoes stale bytes.
        queue_frame('{8'hff});
        // Bytes past the eighth are dropped, so this is still a good frame.
        f = boost_frame(ESC_BYTE, CMD_BOOST, ZONE_TWO, lim_hi, 8'h80);
        f.push_back(8'h00);
        f.push_back(8'hff);
        queue_frame(f);
        drain();

        run_phase(8'd0, 8'd255, 20);
        // Empty range: every target is rejected.
        run_phase(8'd255, 8'd0, 15);
        lo = byte_t'($urandom);
        run_phase(lo, lo, 15);
        lo = byte_t'($urandom);
        hi = byte_t'($urandom);
        if (lo > hi && $urandom_range(0, 3) != 0) run_phase(hi, lo, 30);
        else run_phase(lo, hi, 30);
        run_phase(TARGET_MIN_RESET, TARGET_MAX_RESET, 20);

        if (mismatches == 0) begin
            $display("PASS command_frame_checker_responder");
        end else begin
            $display("FAIL command_frame_checker_responder");
        end
        $finish;
    end

endmodule

// ===== command_frame_checker_responder.f =====
hdl/cfcr_pkg.sv
hdl/cfcr_check.sv
hdl/command_frame_checker_responder.sv
hdl/cfcr_checker.sv
dv/command_frame_checker_responder_tb.sv
